// ----- src/pcm_mix_pkg.sv -----
// Shared widths, status codes and types for the PCM mix accumulator.
`default_nettype none
package pcm_mix_pkg;

  localparam int unsigned SRC_ID_W  = 32;
  localparam int unsigned LEN_W     = 12;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned STATUS_W  = 2;

  typedef logic [STATUS_W-1:0] frame_status_t;

  localparam frame_status_t STAT_OK      = 2'd0;
  localparam frame_status_t STAT_INVALID = 2'd1;
  localparam frame_status_t STAT_UNKNOWN = 2'd2;
  localparam frame_status_t STAT_FULL    = 2'd3;

endpackage
`default_nettype wire

// ----- src/multi_source_pcm_mix_accumulator.sv -----
// Top level of the multi-source PCM mix accumulator.
`default_nettype none
// Multi-source PCM mix accumulator. Each input beat carries one signed
// 16-bit sample of a frame; the beat with sample_index 0 opens the frame and
// decides once whether the whole frame is taken: a zero source id, a zero
// length or a length above SAMPLE_CAP gives "invalid argument", an unknown
// user gives "unknown user", and a new source with the source table already
// holding SOURCE_CAP ids gives "table full". A rejected frame leaves all
// state alone. An accepted frame records a new source, grows the mix length
// and adds its samples into a wrapping 32-bit accumulator entry; positions at
// or beyond the mix length that held before the frame restart from zero.
// Every input beat gives exactly one result beat. The block takes one beat
// per clock with the output side ready. The frame checks and the registered
// read of the accumulator memory load stage 1; from stage 1 the block adds,
// writes the entry back and loads the output register. That single
// read-modify-write on the accumulator memory is what sets the rate; a
// one-entry bypass covers an item that reads the entry the item ahead of
// it writes in the same clock. The accumulator and the source table have
// no reset: an accumulator entry read before any accepted frame wrote it
// returns whatever the memory holds, and source table entries are only
// looked at below the source count, so no clearing pass is needed after
// reset.
module multi_source_pcm_mix_accumulator #(
  parameter int unsigned SAMPLE_CAP = 2048,
  parameter int unsigned SOURCE_CAP = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire [pcm_mix_pkg::SRC_ID_W-1:0]   in_source_id,
  input  wire                               in_source_known,
  input  wire [pcm_mix_pkg::LEN_W-1:0]      in_frame_length,
  input  wire [pcm_mix_pkg::LEN_W-1:0]      in_sample_index,
  input  wire signed [pcm_mix_pkg::SAMPLE_W-1:0] in_sample,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic signed [pcm_mix_pkg::ACC_W-1:0] out_mixed_value,
  output pcm_mix_pkg::frame_status_t        out_frame_status,
  output logic                              out_sample_added
);
  import pcm_mix_pkg::*;

  // Address width of the accumulator memory, source count and table index.
  localparam int unsigned AW = (SAMPLE_CAP > 1) ? $clog2(SAMPLE_CAP) : 1;
  localparam int unsigned CW = $clog2(SOURCE_CAP + 1);
  localparam int unsigned TW = (SOURCE_CAP > 1) ? $clog2(SOURCE_CAP) : 1;
  localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(SAMPLE_CAP);
  localparam logic [CW-1:0]    CAP_SRC = CW'(SOURCE_CAP);

  // ---------------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------------
  logic [SRC_ID_W-1:0] src_table_r [SOURCE_CAP];
  logic [CW-1:0]       src_count_r, src_count_nxt;
  logic [LEN_W-1:0]    mix_len_r, mix_len_nxt;
  logic [LEN_W-1:0]    prior_len_r, prior_len_nxt;
  logic                frame_ok_r, frame_ok_nxt;
  frame_status_t       frame_stat_r, frame_stat_nxt;
  logic                table_wr;

  // Stage 1: checked item waiting on its accumulator read.
  logic                  s1_valid_r;
  logic                  s1_added_r;
  logic                  s1_use_base_r;
  logic                  s1_in_range_r;
  frame_status_t         s1_status_r;
  logic [SAMPLE_W-1:0]   s1_sample_r;
  logic [AW-1:0]         s1_addr_r;
  logic [ACC_W-1:0]      rd_data_r;
  logic                  fwd_hit_r;
  logic [ACC_W-1:0]      fwd_data_r;

  // Output register.
  logic                  out_valid_r;
  logic [ACC_W-1:0]      out_value_r;
  frame_status_t         out_status_r;
  logic                  out_added_r;

  logic [ACC_W-1:0] acc_mem [SAMPLE_CAP];

  logic             in_accept;
  logic             advance;
  logic             in_range;
  logic             start;
  logic             invalid_arg;
  logic             table_hit;
  logic             item_added;
  logic             item_use_base;
  logic [AW-1:0]    rd_addr;
  logic [ACC_W-1:0] stored_val;
  logic [ACC_W-1:0] sum_val;
  logic             wr_en;

  // Move stage 1 forward when the output register is free or being drained.
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign in_accept = in_valid && in_ready;

  assign in_range = in_sample_index < CAP_LEN;
  assign start    = in_sample_index == '0;
  assign rd_addr  = in_range ? in_sample_index[AW-1:0] : '0;

  // Look up the source id among the entries recorded so far.
  always_comb begin
    table_hit = 1'b0;
    for (int i = 0; i < SOURCE_CAP; i++) begin
      if ((CW'(i) < src_count_r) && (src_table_r[i] == in_source_id)) begin
        table_hit = 1'b1;
      end
    end
  end

  assign invalid_arg = (in_source_id == '0) || (in_frame_length == '0) ||
                       (in_frame_length > CAP_LEN);

  // Frame checks in priority order; a rejected frame keeps the mix state.
  always_comb begin
    src_count_nxt  = src_count_r;
    mix_len_nxt    = mix_len_r;
    prior_len_nxt  = prior_len_r;
    frame_ok_nxt   = frame_ok_r;
    frame_stat_nxt = frame_stat_r;
    table_wr       = 1'b0;
    if (start) begin
      priority if (invalid_arg) begin
        frame_ok_nxt   = 1'b0;
        frame_stat_nxt = STAT_INVALID;
      end else if (!in_source_known) begin
        frame_ok_nxt   = 1'b0;
        frame_stat_nxt = STAT_UNKNOWN;
      end else if (!table_hit && (src_count_r >= CAP_SRC)) begin
        frame_ok_nxt   = 1'b0;
        frame_stat_nxt = STAT_FULL;
      end else begin
        frame_ok_nxt   = 1'b1;
        frame_stat_nxt = STAT_OK;
        prior_len_nxt  = mix_len_r;
        if (in_frame_length > mix_len_r) begin
          mix_len_nxt = in_frame_length;
        end
        if (!table_hit) begin
          table_wr      = 1'b1;
          src_count_nxt = src_count_r + CW'(1);
        end
      end
    end
  end

  // Decide add and base selection against the state this item leaves.
  assign item_added = frame_ok_nxt && in_range && (in_sample_index < in_frame_length) &&
                      (in_sample_index < mix_len_nxt);
  assign item_use_base = in_sample_index < prior_len_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_count_r  <= '0;
      mix_len_r    <= '0;
      prior_len_r  <= '0;
      frame_ok_r   <= 1'b0;
      frame_stat_r <= STAT_OK;
    end else if (in_accept) begin
      src_count_r  <= src_count_nxt;
      mix_len_r    <= mix_len_nxt;
      prior_len_r  <= prior_len_nxt;
      frame_ok_r   <= frame_ok_nxt;
      frame_stat_r <= frame_stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && table_wr) begin
      src_table_r[src_count_r[TW-1:0]] <= in_source_id;
    end
  end

  // ---------------------------------------------------------------------
  // Accumulator read-modify-write
  // ---------------------------------------------------------------------
  assign stored_val = fwd_hit_r ? fwd_data_r : rd_data_r;
  assign sum_val    = (s1_use_base_r ? stored_val : '0) +
                      {{(ACC_W-SAMPLE_W){s1_sample_r[SAMPLE_W-1]}}, s1_sample_r};
  assign wr_en      = s1_valid_r && advance && s1_added_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      acc_mem[s1_addr_r] <= sum_val;
    end
    if (in_accept) begin
      rd_data_r <= acc_mem[rd_addr];
    end
  end

  // Bypass: catch the entry being written in the same clock as its read.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      fwd_data_r <= sum_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
      fwd_hit_r  <= wr_en && (s1_addr_r == rd_addr);
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_added_r    <= item_added;
      s1_use_base_r <= item_use_base;
      s1_in_range_r <= in_range;
      s1_status_r   <= frame_stat_nxt;
      s1_sample_r   <= in_sample;
      s1_addr_r     <= rd_addr;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_status_r <= s1_status_r;
      out_added_r  <= s1_added_r;
      if (!s1_in_range_r) begin
        out_value_r <= '0;
      end else if (s1_added_r) begin
        out_value_r <= sum_val;
      end else begin
        out_value_r <= stored_val;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mixed_value  = out_value_r;
  assign out_frame_status = out_status_r;
  assign out_sample_added = out_added_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_added_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_added_r |-> s1_in_range_r)
    else $error("sample marked added outside the accumulator");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    src_count_r <= CAP_SRC)
    else $error("source count beyond table capacity");

  a_mix_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (mix_len_r <= CAP_LEN) && (prior_len_r <= mix_len_r))
    else $error("mix length bookkeeping out of order");

  a_added_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_added_r |-> out_status_r == STAT_OK)
    else $error("sample added for a rejected frame");

  a_rejected_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && start && !frame_ok_nxt |=> $stable(src_count_r) && $stable(mix_len_r))
    else $error("rejected frame changed the mix state");

endmodule
`default_nettype wire
